/* rtl/core/dads_pkg.sv */
// Shared types, constants and calendar helpers for the date stepper.
// No dependencies; imported by dads_step and date_add_days_stepper.
package dads_pkg;

  localparam int TEXT_BITS      = 48;
  localparam int COUNT_FLD_BITS = 12;
  localparam int IN_TDATA_BITS  = 64;
  localparam int COUNT_BITS_DEF = 12;

  // High nibble of every ASCII digit
  localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [6:0] YEAR_LAST = 7'd99;

  // Binary working date
  typedef struct packed {
    logic [6:0] yy;
    logic [3:0] mm;
    logic [5:0] dd;
  } date_t;

  // Days in a month; leap selects 29 for February
  function automatic logic [5:0] month_len(input logic [3:0] mm, input logic leap);
    logic [5:0] len;
    unique case (mm)
      4'd2:                   len = leap ? 6'd29 : 6'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 6'd30;
      default:                len = 6'd31;
    endcase
    return len;
  endfunction

  // Binary 0..99 to two ASCII digits; tens by reciprocal multiply
  function automatic logic [15:0] to_ascii2(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  units;
    prod  = 14'(v) * 14'd103;
    tens  = prod[13:10];
    units = v - 7'(tens) * 7'd10;
    return {ASCII_DIGIT_HI, tens, ASCII_DIGIT_HI, units[3:0]};
  endfunction

endpackage

/* rtl/core/date_add_days_stepper.sv */
// Top level of the date stepper: input word capture, date check, step sequencer, output register.
// Depends on dads_pkg and dads_step.
//
// Takes an ASCII date YYMMDD and a day count, checks the date and adds the count one day per
// clock through a single shared step unit. An input word is taken only when the sequencer is
// idle; it then passes through the check state, the step state for the day_count days and the
// done state, which formats the result into the output register once that register is free, so
// no new word is taken while a date is still being stepped. An invalid date skips the steps and
// is echoed with date_ok low. The next word is accepted as soon as the result is in the output
// register, even if it has not been taken yet.
module date_add_days_stepper #(
  parameter int COUNT_BITS = dads_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [47:0] date_text, [59:48] day_count, [63:60] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [47:0] result_text
  output logic [0:0]  out_tuser   // [0] date_ok
);
  import dads_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [TEXT_BITS-1:0]  text_r;
  logic [COUNT_BITS-1:0] cnt_r;
  date_t                 date_r;
  date_t                 date_step;
  logic                  ok_r;
  logic                  out_valid_r;
  logic [TEXT_BITS-1:0]  out_text_r;
  logic                  out_ok_r;

  logic [3:0] dig [6];
  logic       all_digits;
  logic [6:0] yy_bin, mm_bin, dd_bin;
  logic       date_valid;
  logic       out_free;

  // Split text into digits and check that each byte is an ASCII digit
  always_comb begin
    all_digits = 1'b1;
    for (int i = 0; i < 6; i++) begin
      dig[i] = text_r[8*(5-i) +: 4];
      if (text_r[8*(5-i)+4 +: 4] != ASCII_DIGIT_HI || text_r[8*(5-i) +: 4] > 4'd9) begin
        all_digits = 1'b0;
      end
    end
  end

  assign yy_bin     = 7'(dig[0]) * 7'd10 + 7'(dig[1]);
  assign mm_bin     = 7'(dig[2]) * 7'd10 + 7'(dig[3]);
  assign dd_bin     = 7'(dig[4]) * 7'd10 + 7'(dig[5]);
  assign date_valid = all_digits && (mm_bin >= 7'd1) && (mm_bin <= 7'd12) &&
                      (dd_bin >= 7'd1) && (dd_bin <= 7'd31);

  // Shared one-day step unit
  dads_step u_step (
    .cur (date_r),
    .nxt (date_step)
  );

  assign out_free = !out_valid_r || out_tready;

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_tvalid) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = date_valid ? ST_STEP : ST_DONE;
      ST_STEP:  if (cnt_r == '0) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture input word, load date, advance one day per cycle
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          text_r <= in_tdata[TEXT_BITS-1:0];
          cnt_r  <= COUNT_BITS'(in_tdata[TEXT_BITS +: COUNT_FLD_BITS]);
        end
      end
      ST_CHECK: begin
        ok_r      <= date_valid;
        date_r.yy <= yy_bin;
        date_r.mm <= mm_bin[3:0];
        date_r.dd <= dd_bin[5:0];
      end
      ST_STEP: begin
        if (cnt_r != '0) begin
          date_r <= date_step;
          cnt_r  <= cnt_r - COUNT_BITS'(1);
        end
      end
      default: ;
    endcase
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Format result or echo input
  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && out_free) begin
      out_ok_r   <= ok_r;
      out_text_r <= ok_r ? {to_ascii2(date_r.yy), to_ascii2(7'(date_r.mm)),
                            to_ascii2(7'(date_r.dd))} : text_r;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_text_r;
  assign out_tuser  = out_ok_r;

  // Month stays in range while stepping
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> (date_r.mm >= 4'd1) && (date_r.mm <= 4'd12))
    else $error("month out of range while stepping");

  // Exhausted count hands over to formatting
  a_step_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP && cnt_r == '0 |=> state_r == ST_DONE)
    else $error("step loop did not finish on zero count");

  // A checked date always leaves as ASCII digits
  a_ok_digits: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |->
      out_tdata[47:44] == ASCII_DIGIT_HI && out_tdata[39:36] == ASCII_DIGIT_HI &&
      out_tdata[31:28] == ASCII_DIGIT_HI && out_tdata[23:20] == ASCII_DIGIT_HI &&
      out_tdata[15:12] == ASCII_DIGIT_HI && out_tdata[7:4] == ASCII_DIGIT_HI)
    else $error("valid date result holds a non-digit");

endmodule

/* rtl/core/dads_step.sv */
// Single-day date step unit: advances a binary date by one day.
// Depends on dads_pkg (date_t, month_len).
module dads_step (
  input  dads_pkg::date_t cur,
  output dads_pkg::date_t nxt
);
  import dads_pkg::*;

  logic       leap;
  logic [5:0] lim;
  logic [5:0] dd_inc;

  // Month length for the current month and year
  assign leap   = (cur.yy[1:0] == 2'd0) && (cur.yy != 7'd0);
  assign lim    = month_len(cur.mm, leap && (cur.mm == MONTH_FEB));
  assign dd_inc = cur.dd + 6'd1;

  // Roll day into month and month into year
  always_comb begin
    nxt = cur;
    if (dd_inc > lim) begin
      nxt.dd = 6'd1;
      if (cur.mm == MONTH_DEC) begin
        nxt.mm = 4'd1;
        nxt.yy = (cur.yy == YEAR_LAST) ? 7'd0 : cur.yy + 7'd1;
      end else begin
        nxt.mm = cur.mm + 4'd1;
      end
    end else begin
      nxt.dd = dd_inc;
    end
  end

endmodule
